/* rtl/lsbse_pkg.sv */
// Shared types and constants for the LSB stego stream extractor.
// No dependencies; imported by the extractor and its checker.
package lsbse_pkg;

    localparam int MAGIC_MAX_BYTES_DEF = 8;
    localparam logic [15:0] HEADER_SKIP_RST = 16'd54;
    localparam logic [3:0] MAGIC_LENGTH_RST = 4'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SKIP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_BYTES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_LENGTH = 2'd2;

    localparam int SIZE_W = 31;
    localparam int OUT_TDATA_W = 40;

    localparam logic [1:0] KIND_EXT_CHAR = 2'd0;
    localparam logic [1:0] KIND_SIZE = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_MISMATCH = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        out_byte;
        logic [SIZE_W-1:0] size_value;
        logic              last;
    } result_t;

endpackage

/* rtl/lsb_stego_stream_extractor.sv */
// Top level of the LSB stego stream extractor: bit gathering, phase control,
// configuration registers and a two-entry output buffer.
// Depends on lsbse_pkg.
//
// Usage: carrier bytes of an image file enter on the s_ item channel, one per
// cycle; s_tuser high marks the first byte of a new file and clears progress.
// After header_skip bytes the LSB of each byte is shifted in, MSB first.
// Decoded results leave on the m_ channel: m_tuser is the kind, m_tlast marks
// the last extension character, last payload byte or a zero-size report.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high and writes are expected only while the block is idle.
// Throughput: one item per cycle while s_tready is high; the state update and
// result are formed combinationally from the accepted item, and the result is
// registered in the output register, or in the skid register if that one is held.
// A stalled receiver fills the output register, then the skid register;
// s_tready drops only while the skid register holds an item.
// Reset clears the registers to their defaults and all decoding progress.
module lsb_stego_stream_extractor
    import lsbse_pkg::*;
#(
    parameter int MAGIC_MAX_BYTES = MAGIC_MAX_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] image_byte
    input  logic                   s_tuser,   // [0] restart
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [38:8] size_value, [39] zero
    output logic [1:0]             m_tuser,   // [1:0] kind
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MAGIC_W = 8 * MAGIC_MAX_BYTES;
    localparam int MIDX_W = (MAGIC_MAX_BYTES > 1) ? $clog2(MAGIC_MAX_BYTES) : 1;
    localparam logic [3:0] MAGIC_MAX_L = 4'(MAGIC_MAX_BYTES);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_MAGIC = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_EXT = 3'd3;
    localparam logic [2:0] PH_SIZE = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    logic [15:0]        header_skip_reg;
    logic [MAGIC_W-1:0] magic_bytes_reg;
    logic [3:0]         magic_length_reg;

    logic [2:0]        phase_reg, phase_next;
    logic [15:0]       header_count_reg, header_count_next;
    logic [4:0]        bit_count_reg, bit_count_next;
    logic [31:0]       bit_shift_reg, bit_shift_next;
    logic [SIZE_W-1:0] remaining_reg, remaining_next;
    logic [MIDX_W-1:0] magic_index_reg, magic_index_next;
    logic              magic_ok_reg, magic_ok_next;

    result_t main_reg, skid_reg, res;
    logic    main_valid_reg, skid_valid_reg;
    logic    res_valid;
    logic    accept, pop;

    logic [3:0]        magic_len_eff;
    logic [31:0]       shifted;
    logic [4:0]        bit_count_inc;
    logic              unit_done;
    logic [7:0]        expected;
    logic [SIZE_W-1:0] len_value;
    logic [SIZE_W-1:0] rem_dec;
    logic              ok_now;

    assign accept = s_tvalid && s_tready;
    assign pop = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (magic_length_reg == 4'd0)
            magic_len_eff = 4'd1;
        else if (magic_length_reg > MAGIC_MAX_L)
            magic_len_eff = MAGIC_MAX_L;
        else
            magic_len_eff = magic_length_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        header_count_next = header_count_reg;
        bit_count_next = bit_count_reg;
        bit_shift_next = bit_shift_reg;
        remaining_next = remaining_reg;
        magic_index_next = magic_index_reg;
        magic_ok_next = magic_ok_reg;
        res = '0;
        res_valid = 1'b0;

        if (s_tuser)
        begin
            phase_next = PH_HEADER;
            header_count_next = '0;
            bit_count_next = '0;
            bit_shift_next = '0;
            remaining_next = '0;
            magic_index_next = '0;
            magic_ok_next = 1'b1;
        end

        if (phase_next == PH_HEADER)
        begin
            if (header_count_next < header_skip_reg)
                header_count_next = header_count_next + 16'd1;
            else
                phase_next = PH_MAGIC;
        end

        shifted = {bit_shift_next[30:0], s_tdata[0]};
        bit_count_inc = bit_count_next + 5'd1;
        unit_done = (phase_next == PH_EXTLEN || phase_next == PH_SIZE)
                    ? (bit_count_inc == 5'd0) : (bit_count_inc == 5'd8);
        expected = magic_bytes_reg[8*magic_index_next +: 8];
        len_value = shifted[31] ? '0 : shifted[SIZE_W-1:0];
        rem_dec = remaining_next - SIZE_W'(1);
        ok_now = magic_ok_next && (shifted[7:0] == expected);

        case (phase_next)
            PH_HEADER, PH_DONE:
            begin
            end
            default:
            begin
                bit_shift_next = shifted;
                bit_count_next = bit_count_inc;
                if (unit_done)
                begin
                    bit_count_next = '0;
                    bit_shift_next = '0;
                    case (phase_next)
                        PH_MAGIC:
                        begin
                            magic_ok_next = ok_now;
                            if ((4'(magic_index_next) + 4'd1) >= magic_len_eff)
                            begin
                                magic_index_next = '0;
                                if (!ok_now)
                                begin
                                    phase_next = PH_DONE;
                                    res.kind = KIND_MISMATCH;
                                    res_valid = 1'b1;
                                end
                                else
                                    phase_next = PH_EXTLEN;
                            end
                            else
                                magic_index_next = magic_index_next + MIDX_W'(1);
                        end
                        PH_EXTLEN:
                        begin
                            remaining_next = len_value;
                            phase_next = (len_value == '0) ? PH_SIZE : PH_EXT;
                        end
                        PH_EXT:
                        begin
                            remaining_next = rem_dec;
                            if (rem_dec == '0)
                                phase_next = PH_SIZE;
                            res.kind = KIND_EXT_CHAR;
                            res.out_byte = shifted[7:0];
                            res.last = (rem_dec == '0);
                            res_valid = 1'b1;
                        end
                        PH_SIZE:
                        begin
                            remaining_next = len_value;
                            phase_next = (len_value == '0) ? PH_DONE : PH_DATA;
                            res.kind = KIND_SIZE;
                            res.size_value = len_value;
                            res.last = (len_value == '0);
                            res_valid = 1'b1;
                        end
                        PH_DATA:
                        begin
                            remaining_next = rem_dec;
                            if (rem_dec == '0)
                                phase_next = PH_DONE;
                            res.kind = KIND_PAYLOAD;
                            res.out_byte = shifted[7:0];
                            res.last = (rem_dec == '0);
                            res_valid = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_skip_reg <= HEADER_SKIP_RST;
            magic_bytes_reg <= '0;
            magic_length_reg <= MAGIC_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER_SKIP:  header_skip_reg <= cfg_data[15:0];
                CFG_MAGIC_BYTES:  magic_bytes_reg <= cfg_data[MAGIC_W-1:0];
                CFG_MAGIC_LENGTH: magic_length_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            header_count_reg <= '0;
            bit_count_reg <= '0;
            bit_shift_reg <= '0;
            remaining_reg <= '0;
            magic_index_reg <= '0;
            magic_ok_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            header_count_reg <= header_count_next;
            bit_count_reg <= bit_count_next;
            bit_shift_reg <= bit_shift_next;
            remaining_reg <= remaining_next;
            magic_index_reg <= magic_index_next;
            magic_ok_reg <= magic_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res_valid)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (accept && res_valid)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= res;
            else
                main_reg <= res;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata = {1'b0, main_reg.size_value, main_reg.out_byte};
    assign m_tuser = main_reg.kind;
    assign m_tlast = main_reg.last;

endmodule

/* rtl/lsbse_checker.sv */
// Port-level checker for the LSB stego stream extractor, bound to the top level.
// Depends on lsbse_pkg and lsb_stego_stream_extractor.
module lsbse_checker
    import lsbse_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]             m_tuser,
    input logic                   m_tlast
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output item pending");

    a_mismatch_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_MISMATCH |-> m_tdata == '0 && !m_tlast)
        else $error("mismatch report carries data");

    a_size_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_SIZE
            |-> m_tdata[7:0] == 8'd0 && m_tlast == (m_tdata[38:8] == '0))
        else $error("size report fields inconsistent");

    a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_EXT_CHAR || m_tuser == KIND_PAYLOAD)
            |-> m_tdata[OUT_TDATA_W-1:8] == '0)
        else $error("character item carries a size");

endmodule

bind lsb_stego_stream_extractor lsbse_checker u_lsbse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* verif/lsb_stego_stream_extractor_checker.sv */
// Checker for the LSB stego stream extractor: watches the item, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on lsbse_pkg.
module lsb_stego_stream_extractor_checker
    import lsbse_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [1:0]             m_tuser,
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_MAGIC,
        ST_EXTLEN,
        ST_EXT,
        ST_SIZE,
        ST_DATA,
        ST_DONE
    } stage_t;

    logic [15:0] hdr_skip;
    logic [63:0] magic_chars;
    logic [3:0]  magic_len;

    stage_t      stage;
    logic [15:0] hdr_cnt;
    logic [4:0]  bit_cnt;
    logic [31:0] shreg;
    logic [30:0] chars_left;
    logic [2:0]  mag_idx;
    logic        mag_good;

    result_t     expected_q[$];

    task automatic restart_file();
        stage = ST_HEADER;
        hdr_cnt = '0;
        bit_cnt = '0;
        shreg = '0;
        chars_left = '0;
        mag_idx = '0;
        mag_good = 1'b1;
    endtask

    function automatic logic [30:0] as_length(input logic [31:0] w);
        return w[31] ? 31'd0 : w[30:0];
    endfunction

    // a 32-bit unit completes when the 5-bit counter wraps to zero
    task automatic shift_in(input logic b, input int width, output logic done);
        shreg = {shreg[30:0], b};
        bit_cnt = bit_cnt + 5'd1;
        done = (bit_cnt == width[4:0]);
        if (done)
            bit_cnt = '0;
    endtask

    task automatic decode_carrier(input logic [7:0] b, input logic rs,
                                  output logic hit, output result_t r);
        logic       done;
        logic [7:0] ch;
        int         span;
        hit = 1'b0;
        r = '0;
        if (rs)
            restart_file();
        if (stage == ST_HEADER)
        begin
            if (hdr_cnt < hdr_skip)
            begin
                hdr_cnt = hdr_cnt + 16'd1;
                return;
            end
            stage = ST_MAGIC;
        end
        case (stage)
            ST_MAGIC:
            begin
                shift_in(b[0], 8, done);
                if (done)
                begin
                    ch = shreg[7:0];
                    shreg = '0;
                    if (ch != magic_chars[mag_idx*8 +: 8])
                        mag_good = 1'b0;
                    span = (magic_len == 0) ? 1 :
                           (magic_len > MAGIC_MAX_BYTES_DEF) ? MAGIC_MAX_BYTES_DEF :
                           int'(magic_len);
                    if (int'(mag_idx) + 1 >= span)
                    begin
                        mag_idx = '0;
                        if (!mag_good)
                        begin
                            stage = ST_DONE;
                            hit = 1'b1;
                            r.kind = KIND_MISMATCH;
                        end
                        else
                            stage = ST_EXTLEN;
                    end
                    else
                        mag_idx = mag_idx + 3'd1;
                end
            end
            ST_EXTLEN:
            begin
                shift_in(b[0], 32, done);
                if (done)
                begin
                    chars_left = as_length(shreg);
                    shreg = '0;
                    stage = (chars_left == 0) ? ST_SIZE : ST_EXT;
                end
            end
            ST_EXT, ST_DATA:
            begin
                shift_in(b[0], 8, done);
                if (done)
                begin
                    ch = shreg[7:0];
                    shreg = '0;
                    chars_left = chars_left - 31'd1;
                    hit = 1'b1;
                    r.kind = (stage == ST_EXT) ? KIND_EXT_CHAR : KIND_PAYLOAD;
                    r.out_byte = ch;
                    r.last = (chars_left == 0);
                    if (chars_left == 0)
                        stage = (stage == ST_EXT) ? ST_SIZE : ST_DONE;
                end
            end
            ST_SIZE:
            begin
                shift_in(b[0], 32, done);
                if (done)
                begin
                    chars_left = as_length(shreg);
                    shreg = '0;
                    stage = (chars_left == 0) ? ST_DONE : ST_DATA;
                    hit = 1'b1;
                    r.kind = KIND_SIZE;
                    r.size_value = chars_left;
                    r.last = (chars_left == 0);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        logic    hit;
        if (!rst_n)
        begin
            restart_file();
            hdr_skip = HEADER_SKIP_RST;
            magic_chars = '0;
            magic_len = MAGIC_LENGTH_RST;
            expected_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d byte %02h size %0h last %0b",
                           m_tuser, m_tdata[7:0], m_tdata[38:8], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte,
                               m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[38:8] !== want.size_value)
                    begin
                        $error("size_value: expected %0h, got %0h", want.size_value,
                               m_tdata[38:8]);
                        fail_count++;
                    end
                    if (m_tdata[39] !== 1'b0)
                    begin
                        $error("pad: expected 0, got %0b", m_tdata[39]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEADER_SKIP:  hdr_skip = cfg_data[15:0];
                    CFG_MAGIC_BYTES:  magic_chars = cfg_data;
                    CFG_MAGIC_LENGTH: magic_len = cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                decode_carrier(s_tdata, s_tuser, hit, want);
                if (hit)
                    expected_q.push_back(want);
            end
        end
        pending = expected_q.size();
    end

endmodule

/* verif/lsb_stego_stream_extractor_tb.sv */
// Testbench top for the LSB stego stream extractor: clock, reset, carrier
// file stimulus, configuration writes and the verdict.
// Depends on lsbse_pkg, the extractor and lsb_stego_stream_extractor_checker.
module lsb_stego_stream_extractor_tb;
    import lsbse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_HEADER_SKIP;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int results_checked;

    int          src_idle_pct = 38;
    int          snk_idle_pct = 57;
    int          items_sent = 0;
    int          files_sent = 0;
    logic        file_start = 1'b0;
    logic [15:0] cur_hdr = HEADER_SKIP_RST;
    logic [63:0] cur_magic = '0;
    logic [3:0]  cur_mlen = MAGIC_LENGTH_RST;

    lsb_stego_stream_extractor dut (.*);

    lsb_stego_stream_extractor_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

    function automatic int magic_span(input logic [3:0] n);
        return (n == 0) ? 1 : (n > MAGIC_MAX_BYTES_DEF) ? MAGIC_MAX_BYTES_DEF : int'(n);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= file_start;
        file_start = 1'b0;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // MSB first, one bit in the LSB of each carrier item
    task automatic put_bits(input logic [31:0] w, input int n);
        for (int i = n - 1; i >= 0; i--)
            put_byte({7'($urandom), w[i]});
    endtask

    task automatic open_file(input int hdr_bytes);
        file_start = 1'b1;
        files_sent++;
        repeat (hdr_bytes) put_byte(8'($urandom));
    endtask

    task automatic send_body(input int bad_char, input logic [31:0] ext_word,
                             input int ext_chars, input logic [31:0] size_word,
                             input int pay_bytes, input int junk);
        logic [7:0] c;
        for (int i = 0; i < magic_span(cur_mlen); i++)
        begin
            c = cur_magic[i*8 +: 8];
            if (i == bad_char)
                c = c ^ 8'(1 << $urandom_range(0, 7));
            put_bits({24'd0, c}, 8);
        end
        if (bad_char < 0)
        begin
            put_bits(ext_word, 32);
            repeat (ext_chars) put_bits($urandom, 8);
            if (ext_chars >= (ext_word[31] ? 0 : int'(ext_word[30:0])))
            begin
                put_bits(size_word, 32);
                repeat (pay_bytes) put_bits($urandom, 8);
            end
        end
        repeat (junk) put_byte(8'($urandom));
    endtask

    // hold off until every result is out and the pipeline has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        case (idx)
            CFG_HEADER_SKIP:  cur_hdr = val[15:0];
            CFG_MAGIC_BYTES:  cur_magic = val;
            CFG_MAGIC_LENGTH: cur_mlen = val[3:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(input logic [15:0] hdr, input logic [63:0] magic,
                             input logic [3:0] mlen);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        settle();
        set_reg(CFG_HEADER_SKIP, {noise[63:16], hdr});
        set_reg(CFG_MAGIC_BYTES, magic);
        set_reg(CFG_MAGIC_LENGTH, {noise[63:4], mlen});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_file();
        int          roll;
        int          n_ext;
        int          n_pay;
        logic [31:0] ext_word;
        logic [31:0] size_word;
        roll = $urandom_range(0, 9);
        n_ext = $urandom_range(0, 3);
        n_pay = $urandom_range(0, 6);
        ext_word = n_ext;
        size_word = n_pay;
        if ($urandom_range(0, 7) == 0)
        begin
            ext_word = {1'b1, 31'($urandom)};
            n_ext = 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            size_word = {1'b1, 31'($urandom)};
            n_pay = 0;
        end
        open_file(int'(cur_hdr));
        case (roll)
            0: repeat ($urandom_range(1, 60)) put_byte(8'($urandom));
            1: send_body($urandom_range(0, magic_span(cur_mlen) - 1), ext_word, n_ext,
                         size_word, n_pay, $urandom_range(0, 20));
            2: send_body(-1, {1'b0, 31'($urandom)} | 32'h100, n_ext, size_word, n_pay,
                         $urandom_range(0, 7));
            3: send_body(-1, ext_word, n_ext, {1'b0, 31'($urandom)} | 32'h100, n_pay,
                         $urandom_range(0, 7));
            default: send_body(-1, ext_word, n_ext, size_word, n_pay,
                               $urandom_range(0, 10));
        endcase
    endtask

    initial
    begin
        int target;
        logic [3:0] mlen;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: zero extension length and zero size, then trailing items dropped
        open_file(54);
        send_body(-1, 32'd0, 0, 32'd0, 0, 12);

        configure(16'd0, '1, 4'd15);
        open_file(0);
        send_body(-1, 32'd2, 2, 32'd3, 3, 5);

        configure(16'd1, {$urandom, $urandom}, 4'd0);
        open_file(1);
        send_body(0, 32'd1, 1, 32'd1, 1, 20);

        configure(16'd2, {$urandom, $urandom}, 4'd8);
        open_file(2);
        send_body(7, 32'd1, 1, 32'd1, 1, 10);
        configure(16'd2, {$urandom, $urandom}, 4'd2);
        open_file(2);
        send_body(-1, 32'h8000_0003, 0, 32'hFFFF_FFFF, 0, 6);
        open_file(2);
        send_body(-1, 32'd1, 1, 32'h7FFF_FFFF, 2, 3);
        open_file(2);
        send_body(-1, 32'h7FFF_FFFF, 1, 32'd0, 0, 0);

        // restart part way through the magic characters
        configure(16'd1, 64'd0, 4'd1);
        open_file(1);
        put_bits(32'd0, 5);
        open_file(1);
        send_body(-1, 32'd0, 0, 32'd1, 1, 0);

        // shrink the header below the count reached, then grow it mid-skip
        configure(16'd10, {$urandom, $urandom}, 4'd2);
        open_file(6);
        settle();
        set_reg(CFG_HEADER_SKIP, 64'd3);
        cfg_valid <= 1'b0;
        send_body(-1, 32'd1, 1, 32'd2, 2, 0);
        configure(16'd4, cur_magic, 4'd2);
        open_file(2);
        settle();
        set_reg(CFG_HEADER_SKIP, 64'd6);
        cfg_valid <= 1'b0;
        repeat (4) put_byte(8'($urandom));
        send_body(-1, 32'd2, 2, 32'd1, 1, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 57 : 0;
            snk_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 38 : 0;
            target = items_sent + 60;
            while (items_sent < target)
            begin
                mlen = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 2));
                configure(($urandom_range(0, 5) == 0) ? 16'd54 : 16'($urandom_range(0, 6)),
                          {$urandom, $urandom}, mlen);
                repeat ($urandom_range(1, 3)) random_file();
            end
        end

        // longest header: every item of a short file is dropped
        configure(16'hFFFF, {$urandom, $urandom}, 4'd1);
        open_file(24);

        settle();
        $display("Sent %0d carrier items in %0d files; %0d results checked.",
                 items_sent, files_sent, results_checked);
        $display("Header, magic and length settings ran from their minimum to maximum.");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
